@@ design/assert_macros.svh @@
// Assertion macros shared by the design files.
// No dependencies; define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked property, disabled while reset is high.
`define FAC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked property, active during reset too.
`define FAC_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define FAC_ASSERT(label, clk, rst, prop, msg)
`define FAC_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

@@ design/fac_pkg.sv @@
// Types and constants of the frustum box culler.
// No dependencies.
package fac_pkg;

  localparam int PLANE_COUNT = 6;
  localparam int AXES        = 3;
  localparam int ENTRY_W     = 16;                  // Q4.12 matrix entry
  localparam int COORD_W     = 16;                  // box coordinate
  localparam int TAG_W       = 16;
  localparam int PLANE_W     = ENTRY_W + 1;         // sum of two entries
  localparam int C2_W        = COORD_W + 1;         // doubled centre
  localparam int E2_W        = COORD_W;             // |doubled extent|
  localparam int PROD_C_W    = PLANE_W + C2_W;      // normal times centre
  localparam int PROD_E_W    = PLANE_W + E2_W;      // |normal| times |extent|
  localparam int PAIR_W      = PROD_C_W + 1;        // one axis term
  localparam int TOTAL_W     = PAIR_W + 2;          // three axes plus offset
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_ADDR_W  = 5;
  localparam int REG_SEL_LSB = 3;                   // 8-byte register stride

  localparam logic [CFG_DATA_W-1:0] COL0_RESET = 64'h0000_0000_0000_1000;
  localparam logic [CFG_DATA_W-1:0] COL1_RESET = 64'h0000_0000_1000_0000;
  localparam logic [CFG_DATA_W-1:0] COL2_RESET = 64'h0000_1000_0000_0000;
  localparam logic [CFG_DATA_W-1:0] COL3_RESET = 64'h1000_0000_0000_0000;

  typedef enum logic [1:0] {
    REG_COL0 = 2'd0,
    REG_COL1 = 2'd1,
    REG_COL2 = 2'd2,
    REG_COL3 = 2'd3
  } cfg_reg_t;

  // One plane: normal, magnitude of the normal, and offset.
  typedef struct packed {
    logic [AXES-1:0][PLANE_W-1:0] nrm;
    logic [AXES-1:0][PLANE_W-1:0] nabs;
    logic [PLANE_W-1:0]           ofs;
  } plane_t;

  typedef plane_t [PLANE_COUNT-1:0] plane_set_t;

endpackage

@@ design/fac_box_if.sv @@
// Input channel of the culler: one box and its tag per transfer.
// Depends on fac_pkg.
interface fac_box_if
  import fac_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] box_min_x;
  logic signed [COORD_W-1:0] box_min_y;
  logic signed [COORD_W-1:0] box_min_z;
  logic signed [COORD_W-1:0] box_max_x;
  logic signed [COORD_W-1:0] box_max_y;
  logic signed [COORD_W-1:0] box_max_z;
  logic        [TAG_W-1:0]   object_tag;

  modport source (output valid, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, object_tag, input ready);
  modport sink   (input valid, box_min_x, box_min_y, box_min_z,
                  box_max_x, box_max_y, box_max_z, object_tag, output ready);
endinterface

@@ design/fac_tag_if.sv @@
// Output channel of the culler: one visible tag per transfer.
// Depends on fac_pkg.
interface fac_tag_if
  import fac_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [TAG_W-1:0] visible_tag;

  modport source (output valid, visible_tag, input ready);
  modport sink   (input valid, visible_tag, output ready);
endinterface

@@ design/fac_regs.sv @@
// Matrix column registers behind the APB port, and the six planes
// derived from them (registered). Depends on fac_pkg.
module fac_regs
  import fac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output plane_set_t            planes
);

  logic [3:0][CFG_DATA_W-1:0] cols;
  cfg_reg_t                   sel;
  plane_set_t                 planes_next;

  assign sel    = cfg_reg_t'(paddr[REG_SEL_LSB +: 2]);
  assign prdata = cols[sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      cols[REG_COL0] <= COL0_RESET;
      cols[REG_COL1] <= COL1_RESET;
      cols[REG_COL2] <= COL2_RESET;
      cols[REG_COL3] <= COL3_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (sel)
        REG_COL0: cols[REG_COL0] <= pwdata;
        REG_COL1: cols[REG_COL1] <= pwdata;
        REG_COL2: cols[REG_COL2] <= pwdata;
        REG_COL3: cols[REG_COL3] <= pwdata;
      endcase
    end
  end

  // Plane p: column 3 plus (even p) or minus (odd p) column p/2.
  always_comb begin
    logic signed [PLANE_W-1:0] base;
    logic signed [PLANE_W-1:0] side;
    logic signed [PLANE_W-1:0] sum;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      for (int k = 0; k < AXES + 1; k++) begin
        base = PLANE_W'($signed(cols[REG_COL3][k*ENTRY_W +: ENTRY_W]));
        side = PLANE_W'($signed(cols[p/2][k*ENTRY_W +: ENTRY_W]));
        sum  = (p % 2 == 1) ? base - side : base + side;
        if (k == AXES) begin
          planes_next[p].ofs = sum;
        end else begin
          planes_next[p].nrm[k]  = sum;
          planes_next[p].nabs[k] = sum[PLANE_W-1] ? -sum : sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    planes <= planes_next;
  end

endmodule

@@ design/frustum_aabb_cull_top.sv @@
// Frustum culler top level: APB register block plus a five-register box pipeline.
// Depends on fac_pkg, fac_box_if, fac_tag_if, fac_regs and assert_macros.svh.
//
// Culls axis-aligned boxes against the six planes of a view frustum. Software
// writes the four 64-bit matrix columns (four Q4.12 entries each, entry 0 in
// the low bits) at byte addresses 0, 8, 16 and 24; reads return the column.
// Planes are column 3 plus/minus columns 0, 1, 2, rebuilt in a register in the
// cycle after any write, so columns may only change while no box is in
// flight. Each box transfer yields one visible_tag transfer if the box is
// inside or touches every plane (a total of exactly zero counts as touching),
// and nothing if it is culled. min above max on an axis is not checked; the
// box then acts as if its corners were swapped. Throughput is one box per
// clock while the output is not stalled; a box passes through these registers:
//   s1  doubled centre (min+max) and |doubled extent| (|max-min|)
//   s2  36 multiplies: normal*centre (17x17 bits), |normal|*|extent| (17x16 bits)
//   s3  per plane and axis: sum of those two products
//   s4  per plane: three axis terms plus doubled offset, sign test, AND
//   out result register holding the tag of visible boxes
// Each stage holds while its successor is full, so boxes keep being
// accepted until every stage is occupied behind a stalled output. Culled
// boxes leave from s4 without touching the output register. All sums are
// exact (under 2^38), nothing saturates or rounds.
`include "assert_macros.svh"

module frustum_aabb_cull_top
  import fac_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  fac_box_if.sink               box,
  fac_tag_if.source             result
);

  plane_set_t planes;

  assign pready = 1'b1;

  fac_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .planes  (planes)
  );

  // ---------------- stage control ----------------
  logic v1, v2, v3, v4, vis4, o_valid;
  logic en1, en2, en3, en4, en_out;
  logic accept;

  assign en_out = !o_valid || result.ready;
  assign en4    = !v4 || !vis4 || en_out;   // culled boxes drain without output
  assign en3    = !v3 || en4;
  assign en2    = !v2 || en3;
  assign en1    = !v1 || en2;

  assign box.ready = en1 && !rst;
  assign accept    = box.valid && box.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      v4      <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (en1)    v1      <= accept;
      if (en2)    v2      <= v1;
      if (en3)    v3      <= v2;
      if (en4)    v4      <= v3;
      if (en_out) o_valid <= v4 && vis4;
    end
  end

  // ---------------- s1: centre and extent ----------------
  logic signed [C2_W-1:0]  s1_c2 [AXES];
  logic        [E2_W-1:0]  s1_e2 [AXES];
  logic        [TAG_W-1:0] s1_tag, s2_tag, s3_tag, s4_tag;

  logic signed [COORD_W-1:0] lo [AXES];
  logic signed [COORD_W-1:0] hi [AXES];

  assign lo[0] = box.box_min_x;
  assign lo[1] = box.box_min_y;
  assign lo[2] = box.box_min_z;
  assign hi[0] = box.box_max_x;
  assign hi[1] = box.box_max_y;
  assign hi[2] = box.box_max_z;

  always_ff @(posedge clk) begin
    logic signed [C2_W-1:0] ext;
    logic signed [C2_W-1:0] ext_abs;
    if (en1) begin
      for (int a = 0; a < AXES; a++) begin
        s1_c2[a] <= C2_W'(lo[a]) + C2_W'(hi[a]);
        ext      = C2_W'(hi[a]) - C2_W'(lo[a]);
        ext_abs  = ext[C2_W-1] ? -ext : ext;    // at most 65535
        s1_e2[a] <= ext_abs[E2_W-1:0];
      end
      s1_tag <= box.object_tag;
    end
  end

  // ---------------- s2: products ----------------
  logic signed [PROD_C_W-1:0] s2_pc [PLANE_COUNT][AXES];
  logic        [PROD_E_W-1:0] s2_pe [PLANE_COUNT][AXES];

  always_ff @(posedge clk) begin
    if (en2) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        for (int a = 0; a < AXES; a++) begin
          s2_pc[p][a] <= $signed(planes[p].nrm[a]) * s1_c2[a];
          s2_pe[p][a] <= planes[p].nabs[a] * s1_e2[a];
        end
      end
      s2_tag <= s1_tag;
    end
  end

  // ---------------- s3: per-axis terms ----------------
  logic signed [PAIR_W-1:0] s3_pair [PLANE_COUNT][AXES];

  always_ff @(posedge clk) begin
    logic signed [PAIR_W-1:0] tc;
    logic signed [PAIR_W-1:0] te;
    if (en3) begin
      for (int p = 0; p < PLANE_COUNT; p++) begin
        for (int a = 0; a < AXES; a++) begin
          tc = PAIR_W'(s2_pc[p][a]);
          te = $signed(PAIR_W'({1'b0, s2_pe[p][a]}));
          s3_pair[p][a] <= tc + te;
        end
      end
      s3_tag <= s2_tag;
    end
  end

  // ---------------- s4: plane totals and verdict ----------------
  logic vis_next;

  always_comb begin
    logic signed [PLANE_W:0]    dbl;
    logic signed [TOTAL_W-1:0]  t0;
    logic signed [TOTAL_W-1:0]  t1;
    logic signed [TOTAL_W-1:0]  t2;
    logic signed [TOTAL_W-1:0]  td;
    logic signed [TOTAL_W-1:0]  total;
    vis_next = 1'b1;
    for (int p = 0; p < PLANE_COUNT; p++) begin
      dbl   = $signed({planes[p].ofs, 1'b0});
      t0    = TOTAL_W'(s3_pair[p][0]);
      t1    = TOTAL_W'(s3_pair[p][1]);
      t2    = TOTAL_W'(s3_pair[p][2]);
      td    = TOTAL_W'(dbl);
      total = t0 + t1 + t2 + td;
      if (total[TOTAL_W-1]) vis_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      vis4   <= vis_next;
      s4_tag <= s3_tag;
    end
  end

  // ---------------- output register ----------------
  logic [TAG_W-1:0] o_tag;

  always_ff @(posedge clk) begin
    if (en_out && v4 && vis4) o_tag <= s4_tag;
  end

  assign result.valid       = o_valid;
  assign result.visible_tag = o_tag;

  // ---------------- checks ----------------
  `FAC_ASSERT(a_accept_loads_s1, clk, rst, accept |=> v1, "accepted box missing from s1")
  `FAC_ASSERT(a_visible_held, clk, rst, (v4 && vis4 && !en_out) |=> (v4 && vis4),
              "visible box dropped from s4 during output stall")
  `FAC_ASSERT(a_culled_silent, clk, rst, (v4 && !vis4 && result.ready) |=> !result.valid,
              "culled box produced a result")
  `FAC_ASSERT(a_full_blocks, clk, rst,
              (o_valid && !result.ready && v1 && v2 && v3 && v4 && vis4) |-> !box.ready,
              "input accepted with every stage full")
  `FAC_ASSERT_ALWAYS(a_no_accept_in_reset, clk, rst |-> !box.ready,
                     "input ready during reset")

endmodule
